// ----- src/sfi_pkg.sv -----
// ----------------------------------------------------------------------------
// sfi_pkg
// Shared constants, types and helpers of the sampled function interpolator.
// ----------------------------------------------------------------------------
package sfi_pkg;

  localparam int SAMPLE_DEPTH = 1024;
  localparam int ADDR_W       = $clog2(SAMPLE_DEPTH);
  localparam int COUNT_W      = 11;
  localparam int FRAC_W       = 16;
  localparam int VALUE_W      = 32;
  localparam int INTEG_W      = 48;
  localparam int TIME_W       = 32;
  localparam int K_W          = TIME_W - FRAC_W;
  localparam int END_W        = 26;
  localparam int MODE_W       = 2;
  localparam int MUL_A_W      = 50;
  localparam int MUL_B_W      = 32;
  localparam int PROD_W       = MUL_A_W + MUL_B_W;
  localparam int WIDE_W       = PROD_W + 2;
  localparam int DIV_W        = 32;
  localparam int DIV_CNT_W    = $clog2(DIV_W + 1);
  localparam int PADDR_W      = 5;
  localparam int REG_IDX_W    = 3;

  localparam logic [REG_IDX_W-1:0] REG_SAMPLE_COUNT  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_INTERP_MODE   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_BORDER_CYCLIC = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_BORDER_LEVEL  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_END_TIME      = 3'd4;

  localparam logic [MODE_W-1:0] MODE_LINEAR = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RIGHT  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LEFT   = 2'd2;

  localparam logic signed [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
  localparam logic signed [INTEG_W-1:0] INTEG_MIN = {1'b1, {(INTEG_W-1){1'b0}}};

  typedef logic signed [WIDE_W-1:0] wide_t;

  typedef struct packed {
    logic [COUNT_W-1:0]        sample_count;
    logic [MODE_W-1:0]         interp_mode;
    logic                      border_cyclic;
    logic signed [VALUE_W-1:0] border_level;
    logic [END_W-1:0]          end_time;
  } cfg_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_LOAD,
    OP_RES_ZERO,
    OP_DIV_START,
    OP_EV_SET,
    OP_RD_HI,
    OP_LATCH_HI,
    OP_MUL_START,
    OP_MUL_DONE,
    OP_RES_EV,
    OP_RES_CYC
  } dp_op_t;

  typedef enum logic [2:0] {
    MS_EV_FAR,
    MS_EV_INT,
    MS_EV_VAL,
    MS_BL_T,
    MS_BL_DT,
    MS_IEND_Q
  } mul_sel_t;

  typedef enum logic [1:0] {
    EV_T,
    EV_END,
    EV_U
  } ev_sel_t;

  typedef enum logic [2:0] {
    G_PLAIN,
    G_BORDER,
    G_CYC_END,
    G_CYC_U,
    G_CONST
  } goal_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_EV_SET,
    ST_RD_LO,
    ST_RD_HI,
    ST_RD_DONE,
    ST_MI_GO,
    ST_MI_WAIT,
    ST_MV_GO,
    ST_MV_WAIT,
    ST_EV_END,
    ST_MX_GO,
    ST_MX_WAIT,
    ST_OUT
  } state_t;

  typedef struct packed {
    dp_op_t   op;
    mul_sel_t msel;
    ev_sel_t  esel;
  } dp_cmd_t;

  typedef struct packed {
    logic is_load;
    logic t_neg;
    logic n_zero;
    logic t_gt_end;
    logic cyc_ok;
    logic far;
    logic lin;
    logic mul_busy;
    logic div_busy;
  } dp_status_t;

  function automatic logic signed [INTEG_W-1:0] sat48(input wide_t x);
    logic signed [INTEG_W-1:0] r;
    if (x > wide_t'(INTEG_MAX)) r = INTEG_MAX;
    else if (x < wide_t'(INTEG_MIN)) r = INTEG_MIN;
    else r = x[INTEG_W-1:0];
    return r;
  endfunction

endpackage

// ----- src/sfi_if.sv -----
// ----------------------------------------------------------------------------
// sfi_req_if / sfi_rsp_if
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface sfi_req_if import sfi_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      req_type;
  logic [ADDR_W-1:0]         sample_index;
  logic signed [VALUE_W-1:0] sample_value;
  logic signed [TIME_W-1:0]  query_time;

  modport source (output valid, req_type, sample_index, sample_value, query_time,
                  input ready);
  modport sink (input valid, req_type, sample_index, sample_value, query_time,
                output ready);
endinterface

interface sfi_rsp_if import sfi_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] func_value;
  logic signed [INTEG_W-1:0] integral_value;
  logic                      load_error;

  modport source (output valid, func_value, integral_value, load_error, input ready);
  modport sink (input valid, func_value, integral_value, load_error, output ready);
endinterface

// ----- src/sfi_mul.sv -----
// ----------------------------------------------------------------------------
// sfi_mul
// Shift-add multiplier: signed operand times unsigned operand, one bit a cycle.
// ----------------------------------------------------------------------------
module sfi_mul import sfi_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic signed [MUL_A_W-1:0] a,
  input  logic [MUL_B_W-1:0]        b,
  output logic                      busy,
  output logic signed [PROD_W-1:0]  prod
);

  logic signed [PROD_W-1:0] ash;
  logic [MUL_B_W-1:0]       bsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && bsh[MUL_B_W-1:1] == '0) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      prod <= '0;
      ash  <= PROD_W'(a);
      bsh  <= b;
    end else if (busy) begin
      if (bsh[0]) begin
        prod <= prod + ash;
      end
      ash <= ash <<< 1;
      bsh <= bsh >> 1;
    end
  end

endmodule

// ----- src/sfi_div.sv -----
// ----------------------------------------------------------------------------
// sfi_div
// Restoring divider for the cyclic wrap: one quotient bit a cycle.
// ----------------------------------------------------------------------------
module sfi_div import sfi_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIV_W-1:0]  dividend,
  input  logic [END_W-1:0]  divisor,
  output logic              busy,
  output logic [DIV_W-1:0]  quot,
  output logic [END_W-1:0]  rem
);

  logic [DIV_CNT_W-1:0] cnt;
  logic [END_W:0]       trial;
  logic [END_W:0]       diff;

  assign trial = {rem, quot[DIV_W-1]};
  assign diff  = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= DIV_CNT_W'(DIV_W);
    end else if (busy) begin
      cnt <= cnt - DIV_CNT_W'(1);
      if (cnt == DIV_CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quot <= dividend;
    end else if (busy) begin
      if (trial >= {1'b0, divisor}) begin
        rem  <= diff[END_W-1:0];
        quot <= {quot[DIV_W-2:0], 1'b1};
      end else begin
        rem  <= trial[END_W-1:0];
        quot <= {quot[DIV_W-2:0], 1'b0};
      end
    end
  end

endmodule

// ----- src/sfi_dp.sv -----
// ----------------------------------------------------------------------------
// sfi_dp
// Datapath: sample and integral tables, operand registers, result registers.
// ----------------------------------------------------------------------------
module sfi_dp import sfi_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  cfg_t                       cfg,
  input  dp_cmd_t                    cmd,
  input  logic                       in_type,
  input  logic [ADDR_W-1:0]          in_index,
  input  logic signed [VALUE_W-1:0]  in_value,
  input  logic signed [TIME_W-1:0]   in_time,
  output dp_status_t                 status,
  output logic signed [VALUE_W-1:0]  func_value,
  output logic signed [INTEG_W-1:0]  integral_value,
  output logic                       load_error
);

  logic signed [VALUE_W-1:0] sample_mem [SAMPLE_DEPTH];
  logic signed [INTEG_W-1:0] integ_mem [SAMPLE_DEPTH];
  logic signed [VALUE_W-1:0] rd_y;
  logic signed [INTEG_W-1:0] rd_p;

  logic                      cap_type;
  logic [ADDR_W-1:0]         cap_idx;
  logic signed [VALUE_W-1:0] cap_val;
  logic [TIME_W-1:0]         cap_t;

  logic [COUNT_W-1:0]        next_load_index;
  logic signed [VALUE_W-1:0] prev_sample;
  logic signed [INTEG_W-1:0] prev_integral;

  logic [TIME_W-1:0]         et;
  logic signed [VALUE_W-1:0] yl, yr, ev_v;
  logic signed [INTEG_W-1:0] pl, pr, ev_i, cyc_acc;

  logic [COUNT_W-1:0]        n_cnt, last_full;
  logic [ADDR_W-1:0]         last, lo_addr, hi_addr, rd_addr;
  logic [K_W-1:0]            k;
  logic [FRAC_W-1:0]         f;
  logic                      far;
  logic [TIME_W-1:0]         span;
  logic signed [VALUE_W:0]   ydiff;
  logic signed [INTEG_W:0]   pdiff;

  logic                      mul_start, mul_busy;
  logic signed [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0]        mul_b;
  logic signed [PROD_W-1:0]  prod, prod_sh;

  logic                      div_busy;
  logic [DIV_W-1:0]          div_q;
  logic [END_W-1:0]          div_r;

  logic                      load_ok;
  logic signed [VALUE_W:0]   pair_sum, area;
  logic signed [INTEG_W-1:0] load_integ;
  logic                      lin;

  // table geometry for the current evaluation time
  assign n_cnt     = (cfg.sample_count > COUNT_W'(SAMPLE_DEPTH)) ?
                     COUNT_W'(SAMPLE_DEPTH) : cfg.sample_count;
  assign last_full = n_cnt - COUNT_W'(1);
  assign last      = last_full[ADDR_W-1:0];
  assign k         = et[TIME_W-1:FRAC_W];
  assign f         = et[FRAC_W-1:0];
  assign far       = k >= K_W'(last);
  assign span      = et - (TIME_W'(last) << FRAC_W);
  assign lo_addr   = far ? last : k[ADDR_W-1:0];
  assign hi_addr   = lo_addr + ADDR_W'(1);
  assign rd_addr   = (cmd.op == OP_RD_HI) ? hi_addr : lo_addr;
  assign ydiff     = (VALUE_W+1)'(yr) - (VALUE_W+1)'(yl);
  assign pdiff     = (INTEG_W+1)'(pr) - (INTEG_W+1)'(pl);
  assign lin       = cfg.interp_mode != MODE_RIGHT && cfg.interp_mode != MODE_LEFT;

  always_comb begin
    case (cmd.msel)
      MS_EV_FAR: begin
        mul_a = MUL_A_W'(yl);
        mul_b = span;
      end
      MS_EV_INT: begin
        mul_a = MUL_A_W'(pdiff);
        mul_b = MUL_B_W'(f);
      end
      MS_EV_VAL: begin
        mul_a = MUL_A_W'(ydiff);
        mul_b = MUL_B_W'(f);
      end
      MS_BL_T: begin
        mul_a = MUL_A_W'(cfg.border_level);
        mul_b = cap_t;
      end
      MS_BL_DT: begin
        mul_a = MUL_A_W'(cfg.border_level);
        mul_b = cap_t - TIME_W'(cfg.end_time);
      end
      default: begin
        mul_a = MUL_A_W'(ev_i);
        mul_b = div_q;
      end
    endcase
  end

  assign mul_start = cmd.op == OP_MUL_START;
  assign prod_sh   = prod >>> FRAC_W;

  sfi_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .busy  (mul_busy),
    .prod  (prod)
  );

  sfi_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.op == OP_DIV_START),
    .dividend (cap_t),
    .divisor  (cfg.end_time),
    .busy     (div_busy),
    .quot     (div_q),
    .rem      (div_r)
  );

  // load: in-order append, or restart at index zero
  assign load_ok  = ({1'b0, cap_idx} == next_load_index) || (cap_idx == '0);
  assign pair_sum = (VALUE_W+1)'(prev_sample) + (VALUE_W+1)'(cap_val);

  always_comb begin
    case (cfg.interp_mode)
      MODE_RIGHT: area = (VALUE_W+1)'(cap_val);
      MODE_LEFT:  area = (VALUE_W+1)'(prev_sample);
      default:    area = pair_sum >>> 1;
    endcase
  end

  assign load_integ = (cap_idx == '0) ? '0 :
                      sat48(wide_t'(prev_integral) + wide_t'(area));

  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD && load_ok) begin
      sample_mem[cap_idx] <= cap_val;
      integ_mem[cap_idx]  <= load_integ;
    end
    rd_y <= sample_mem[rd_addr];
    rd_p <= integ_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_load_index <= '0;
      prev_sample     <= '0;
    end else if (cmd.op == OP_LOAD && load_ok) begin
      next_load_index <= COUNT_W'(cap_idx) + COUNT_W'(1);
      prev_sample     <= cap_val;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_CAPTURE: begin
        cap_type <= in_type;
        cap_idx  <= in_index;
        cap_val  <= in_value;
        cap_t    <= in_time;
      end
      OP_LOAD: begin
        func_value     <= '0;
        integral_value <= '0;
        load_error     <= !load_ok;
        if (load_ok) begin
          prev_integral <= load_integ;
        end
      end
      OP_RES_ZERO: begin
        func_value     <= '0;
        integral_value <= '0;
        load_error     <= 1'b0;
      end
      OP_EV_SET: begin
        case (cmd.esel)
          EV_T:    et <= cap_t;
          EV_END:  et <= TIME_W'(cfg.end_time);
          default: et <= TIME_W'(div_r);
        endcase
      end
      OP_RD_HI: begin
        yl <= rd_y;
        pl <= rd_p;
      end
      OP_LATCH_HI: begin
        yr <= rd_y;
        pr <= rd_p;
      end
      OP_MUL_DONE: begin
        case (cmd.msel)
          MS_EV_FAR: begin
            ev_i <= sat48(wide_t'(pl) + wide_t'(prod_sh));
            ev_v <= yl;
          end
          MS_EV_INT: begin
            ev_i <= sat48(wide_t'(pl) + wide_t'(prod_sh));
            // right-value mode holds the left sample only on the knot itself
            ev_v <= (cfg.interp_mode == MODE_RIGHT && f != '0) ? yr : yl;
          end
          MS_EV_VAL: begin
            ev_v <= yl + prod_sh[VALUE_W-1:0];
          end
          MS_BL_T: begin
            func_value     <= cfg.border_level;
            integral_value <= sat48(wide_t'(prod_sh));
            load_error     <= 1'b0;
          end
          MS_BL_DT: begin
            func_value     <= cfg.border_level;
            integral_value <= sat48(wide_t'(ev_i) + wide_t'(prod_sh));
            load_error     <= 1'b0;
          end
          default: begin
            cyc_acc <= sat48(wide_t'(prod));
          end
        endcase
      end
      OP_RES_EV: begin
        func_value     <= ev_v;
        integral_value <= ev_i;
        load_error     <= 1'b0;
      end
      OP_RES_CYC: begin
        func_value     <= ev_v;
        integral_value <= sat48(wide_t'(cyc_acc) + wide_t'(ev_i));
        load_error     <= 1'b0;
      end
      default: begin
      end
    endcase
  end

  assign status.is_load  = !cap_type;
  assign status.t_neg    = cap_t[TIME_W-1];
  assign status.n_zero   = cfg.sample_count == '0;
  assign status.t_gt_end = cap_t > TIME_W'(cfg.end_time);
  assign status.cyc_ok   = cfg.border_cyclic && cfg.end_time != '0;
  assign status.far      = far;
  assign status.lin      = lin;
  assign status.mul_busy = mul_busy;
  assign status.div_busy = div_busy;

endmodule

// ----- src/sfi_ctrl.sv -----
// ----------------------------------------------------------------------------
// sfi_ctrl
// Sequencer: steps one transaction through the datapath operations.
// ----------------------------------------------------------------------------
module sfi_ctrl import sfi_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  state_t state, state_next;
  goal_t  goal, goal_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      goal  <= G_PLAIN;
    end else begin
      state <= state_next;
      goal  <= goal_next;
    end
  end

  always_comb begin
    state_next = state;
    goal_next  = goal;
    unique case (state)
      ST_IDLE:     if (in_valid) state_next = ST_DECIDE;
      ST_DECIDE: begin
        if (status.is_load || status.t_neg) begin
          state_next = ST_OUT;
        end else if (status.n_zero) begin
          goal_next  = G_CONST;
          state_next = ST_MX_GO;
        end else if (!status.t_gt_end) begin
          goal_next  = G_PLAIN;
          state_next = ST_EV_SET;
        end else if (!status.cyc_ok) begin
          goal_next  = G_BORDER;
          state_next = ST_EV_SET;
        end else begin
          goal_next  = G_CYC_END;
          state_next = ST_DIV_GO;
        end
      end
      ST_DIV_GO:   state_next = ST_DIV_WAIT;
      ST_DIV_WAIT: if (!status.div_busy) state_next = ST_EV_SET;
      ST_EV_SET:   state_next = ST_RD_LO;
      ST_RD_LO:    state_next = ST_RD_HI;
      ST_RD_HI:    state_next = ST_RD_DONE;
      ST_RD_DONE:  state_next = ST_MI_GO;
      ST_MI_GO:    state_next = ST_MI_WAIT;
      ST_MI_WAIT: begin
        if (!status.mul_busy) begin
          state_next = (!status.far && status.lin) ? ST_MV_GO : ST_EV_END;
        end
      end
      ST_MV_GO:    state_next = ST_MV_WAIT;
      ST_MV_WAIT:  if (!status.mul_busy) state_next = ST_EV_END;
      ST_EV_END: begin
        if (goal == G_PLAIN || goal == G_CYC_U) state_next = ST_OUT;
        else state_next = ST_MX_GO;
      end
      ST_MX_GO:    state_next = ST_MX_WAIT;
      ST_MX_WAIT: begin
        if (!status.mul_busy) begin
          if (goal == G_CYC_END) begin
            goal_next  = G_CYC_U;
            state_next = ST_EV_SET;
          end else begin
            state_next = ST_OUT;
          end
        end
      end
      ST_OUT:      if (out_ready) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    cmd.op    = OP_NONE;
    cmd.msel  = MS_EV_INT;
    cmd.esel  = EV_END;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.op = OP_CAPTURE;
      end
      ST_DECIDE: begin
        if (status.is_load) cmd.op = OP_LOAD;
        else if (status.t_neg) cmd.op = OP_RES_ZERO;
      end
      ST_DIV_GO:  cmd.op = OP_DIV_START;
      ST_EV_SET: begin
        cmd.op = OP_EV_SET;
        if (goal == G_PLAIN) cmd.esel = EV_T;
        else if (goal == G_CYC_U) cmd.esel = EV_U;
        else cmd.esel = EV_END;
      end
      ST_RD_HI:   cmd.op = OP_RD_HI;
      ST_RD_DONE: cmd.op = OP_LATCH_HI;
      ST_MI_GO, ST_MI_WAIT: begin
        cmd.msel = status.far ? MS_EV_FAR : MS_EV_INT;
        if (state == ST_MI_GO) cmd.op = OP_MUL_START;
        else if (!status.mul_busy) cmd.op = OP_MUL_DONE;
      end
      ST_MV_GO, ST_MV_WAIT: begin
        cmd.msel = MS_EV_VAL;
        if (state == ST_MV_GO) cmd.op = OP_MUL_START;
        else if (!status.mul_busy) cmd.op = OP_MUL_DONE;
      end
      ST_EV_END: begin
        if (goal == G_PLAIN) cmd.op = OP_RES_EV;
        else if (goal == G_CYC_U) cmd.op = OP_RES_CYC;
      end
      ST_MX_GO, ST_MX_WAIT: begin
        if (goal == G_CONST) cmd.msel = MS_BL_T;
        else if (goal == G_BORDER) cmd.msel = MS_BL_DT;
        else cmd.msel = MS_IEND_Q;
        if (state == ST_MX_GO) cmd.op = OP_MUL_START;
        else if (!status.mul_busy) cmd.op = OP_MUL_DONE;
      end
      ST_OUT:     out_valid = 1'b1;
      default: begin
      end
    endcase
  end

endmodule

// ----- src/sampled_function_interpolator.sv -----
// ----------------------------------------------------------------------------
// sampled_function_interpolator
// Piecewise table interpolation of a uniformly sampled function and its
// running integral, with border and cyclic handling past the end time.
// ----------------------------------------------------------------------------
// Usage: req carries loads (req_type 0) that append samples in index order and
// queries (req_type 1) at a Q16.16 time. rsp returns one transaction per
// request: value, saturated integral and a load error flag.
// The block works on one transaction at a time. Queries use the shift-add
// multiplier (one bit of its unsigned operand a cycle); cyclic queries also
// use the divider of the cyclic wrap and run two table evaluations.
// After the result is taken the block returns to idle, where it can accept
// the next request. A result waits in the output registers while rsp.ready
// is low; req.ready stays low until it is taken. Reset returns to idle,
// clears the load sequence and the configuration registers; the tables are
// not cleared and are valid only where loaded. Configuration is written over
// the APB port; the user must write it only while idle, as the block itself
// does not enforce it.
// ----------------------------------------------------------------------------
module sampled_function_interpolator import sfi_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  sfi_req_if.sink            req,
  sfi_rsp_if.source          rsp,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  cfg_t                 cfg;
  dp_cmd_t              cmd;
  dp_status_t           status;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_SAMPLE_COUNT:  cfg.sample_count  <= pwdata[COUNT_W-1:0];
        REG_INTERP_MODE:   cfg.interp_mode   <= pwdata[MODE_W-1:0];
        REG_BORDER_CYCLIC: cfg.border_cyclic <= pwdata[0];
        REG_BORDER_LEVEL:  cfg.border_level  <= pwdata;
        REG_END_TIME:      cfg.end_time      <= pwdata[END_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SAMPLE_COUNT:  prdata = 32'(cfg.sample_count);
      REG_INTERP_MODE:   prdata = 32'(cfg.interp_mode);
      REG_BORDER_CYCLIC: prdata = 32'(cfg.border_cyclic);
      REG_BORDER_LEVEL:  prdata = cfg.border_level;
      REG_END_TIME:      prdata = 32'(cfg.end_time);
      default:           prdata = '0;
    endcase
  end

  sfi_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .status    (status),
    .cmd       (cmd)
  );

  sfi_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .cmd            (cmd),
    .in_type        (req.req_type),
    .in_index       (req.sample_index),
    .in_value       (req.sample_value),
    .in_time        (req.query_time),
    .status         (status),
    .func_value     (rsp.func_value),
    .integral_value (rsp.integral_value),
    .load_error     (rsp.load_error)
  );

`ifndef SYNTHESIS
  // one transaction in flight: no new request while a result is offered
  a_no_accept_while_out: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !req.ready)
    else $error("request accepted while a result is pending");

  // an accepted transaction leaves the block busy: not ready and no result offered
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> (!req.ready && !rsp.valid))
    else $error("block not busy after accepting a transaction");

  // a rejected load carries zero value and integral
  a_error_zero_payload: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.load_error) |-> (rsp.func_value == '0 && rsp.integral_value == '0))
    else $error("load error with nonzero payload");
`endif

endmodule

// ----- verif/tb_sampled_function_interpolator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sampled_function_interpolator
// Self-checking bench: loads sample tables over the request channel, writes
// the registers over APB between phases, and checks every result transaction
// against a fixed-point interpolation model in the bench or a plan row's values.
// ----------------------------------------------------------------------------
module tb_sampled_function_interpolator;
  import sfi_pkg::*;

  localparam bit          REQ_LOAD     = 1'b0;
  localparam bit          REQ_QUERY    = 1'b1;
  localparam logic [1:0]  MODE_UNKNOWN = 2'd3;
  localparam logic [25:0] END_MAX      = 26'h3FF0000;
  localparam longint      I48_HI       = (64'sd1 <<< 47) - 1;
  localparam longint      I48_LO       = -(64'sd1 <<< 47);
  localparam int          CYCLE_LIMIT  = 1000000;

  typedef struct {
    int                        ph;
    bit                        rt;
    logic [ADDR_W-1:0]         idx;
    logic signed [VALUE_W-1:0] val;
    logic signed [TIME_W-1:0]  qt;
    bit                        typed;
    logic signed [VALUE_W-1:0] efv;
    logic signed [INTEG_W-1:0] eiv;
    bit                        eerr;
  } plan_row_t;

  typedef struct {
    logic signed [VALUE_W-1:0] fv;
    logic signed [INTEG_W-1:0] iv;
    logic                      err;
  } interp_result_t;

  typedef struct {
    logic [COUNT_W-1:0] cnt;
    logic [MODE_W-1:0]  mode;
    logic               cyc;
    logic [31:0]        bl;
    logic [END_W-1:0]   et;
  } setting_t;

  logic clk = 1'b0;
  logic rst;
  logic psel, penable, pwrite, pready;
  logic [PADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;

  sfi_req_if req_ch ();
  sfi_rsp_if rsp_ch ();

  sampled_function_interpolator dut (
    .clk(clk), .rst(rst), .req(req_ch), .rsp(rsp_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // model state
  longint      samples [SAMPLE_DEPTH];
  longint      running_area [SAMPLE_DEPTH];
  int unsigned next_index;
  longint      prev_value;
  int unsigned cfg_cnt, cfg_mode, cfg_cyc;
  longint      cfg_bl, cfg_et;
  int          written_hi;

  interp_result_t pending_results[$];
  int src_idle_pct, snk_stall_pct;
  int mismatches, cycles, sent_loads, sent_queries, checked;

  plan_row_t load_query_plan [] = '{
    '{0, REQ_QUERY, 0, 0, 32'h0, 1, 0, 0, 0},
    '{0, REQ_QUERY, 0, 0, 32'h80000000, 1, 0, 0, 0},
    '{0, REQ_LOAD, 10'd7, 32'h1234, 0, 1, 0, 0, 1},
    '{0, REQ_LOAD, 10'd0, 32'h7FFFFFFF, 0, 1, 0, 0, 0},
    '{0, REQ_LOAD, 10'd1, 32'h80000000, 0, 1, 0, 0, 0},
    '{0, REQ_LOAD, 10'd2, 32'h0, 0, 1, 0, 0, 0},
    '{0, REQ_LOAD, 10'd3, 32'h00018000, 0, 1, 0, 0, 0},
    '{0, REQ_LOAD, 10'd4, 32'hFFFFFFFB, 0, 1, 0, 0, 0},
    '{0, REQ_LOAD, 10'd1023, 32'hFFFFFFFF, 0, 1, 0, 0, 1},
    '{0, REQ_LOAD, 10'd2, 32'h5, 0, 1, 0, 0, 1},
    '{1, REQ_QUERY, 0, 0, 32'h0, 0, 0, 0, 0},
    '{1, REQ_QUERY, 0, 0, 32'h8000, 0, 0, 0, 0},
    '{1, REQ_QUERY, 0, 0, 32'h18000, 0, 0, 0, 0},
    '{1, REQ_QUERY, 0, 0, 32'h40000, 0, 0, 0, 0},
    '{1, REQ_QUERY, 0, 0, 32'h48000, 0, 0, 0, 0},
    '{1, REQ_QUERY, 0, 0, 32'h50000, 0, 0, 0, 0},
    '{1, REQ_QUERY, 0, 0, 32'h7FFFFFFF, 0, 0, 0, 0},
    '{2, REQ_QUERY, 0, 0, 32'h10000, 0, 0, 0, 0},
    '{2, REQ_QUERY, 0, 0, 32'h14000, 0, 0, 0, 0},
    '{2, REQ_QUERY, 0, 0, 32'h2C000, 0, 0, 0, 0},
    '{2, REQ_QUERY, 0, 0, 32'h7FFFFFFF, 0, 0, 0, 0},
    '{3, REQ_QUERY, 0, 0, 32'h10000, 1, 32'h7FFFFFFF, 48'h7FFFFFFF, 0},
    '{3, REQ_QUERY, 0, 0, 32'h7FFFFFFF, 0, 0, 0, 0},
    '{4, REQ_QUERY, 0, 0, 32'h18000, 0, 0, 0, 0},
    '{4, REQ_QUERY, 0, 0, 32'h30000, 0, 0, 0, 0}
  };

  setting_t plan_settings [5] = '{
    '{11'd0, MODE_LINEAR, 1'b0, 32'h0, 26'h0},
    '{11'd5, MODE_LINEAR, 1'b0, 32'h80000000, 26'h50000},
    '{11'd5, MODE_RIGHT, 1'b1, 32'h7FFFFFFF, 26'h2C000},
    '{11'd0, MODE_LEFT, 1'b1, 32'h7FFFFFFF, END_MAX},
    '{11'd5, MODE_UNKNOWN, 1'b0, 32'h0, 26'h0}
  };

  function automatic longint clip48(longint x);
    if (x > I48_HI) return I48_HI;
    if (x < I48_LO) return I48_LO;
    return x;
  endfunction

  // floor(d * f / 2^16) without overflow
  function automatic longint frac_scale(longint d, longint f);
    longint hi, lo;
    hi = d >>> FRAC_W;
    lo = d - hi * 65536;
    return hi * f + ((lo * f) >>> FRAC_W);
  endfunction

  function automatic longint area_times(longint p, longint q);
    longint mag;
    if (p == 0 || q == 0) return 0;
    mag = (p < 0) ? -p : p;
    if (mag > (64'sd1 <<< 47) / q) return (p < 0) ? I48_LO : I48_HI;
    return clip48(p * q);
  endfunction

  function automatic longint value_at_time(longint t, int last);
    longint k, f, yl, yr;
    k = t >>> FRAC_W;
    f = t & 64'hFFFF;
    if (k >= last) return samples[last];
    yl = samples[k];
    yr = samples[k + 1];
    if (cfg_mode == MODE_RIGHT) return (f == 0) ? yl : yr;
    if (cfg_mode == MODE_LEFT) return yl;
    return yl + frac_scale(yr - yl, f);
  endfunction

  function automatic longint area_to_time(longint t, int last);
    longint k, f, pl;
    k = t >>> FRAC_W;
    f = t & 64'hFFFF;
    if (k >= last)
      return clip48(running_area[last] +
                    ((samples[last] * (t - longint'(last) * 65536)) >>> FRAC_W));
    pl = running_area[k];
    return clip48(pl + frac_scale(running_area[k + 1] - pl, f));
  endfunction

  function automatic interp_result_t interp_predict(plan_row_t it);
    interp_result_t r;
    longint t, y, area, q, u;
    int n, idx;
    r = '{0, 0, 0};
    if (it.rt == REQ_LOAD) begin
      idx = it.idx;
      y = it.val;
      if (idx == next_index || idx == 0) begin
        samples[idx] = y;
        if (idx == 0) running_area[0] = 0;
        else begin
          if (cfg_mode == MODE_RIGHT) area = y;
          else if (cfg_mode == MODE_LEFT) area = prev_value;
          else area = (prev_value + y) >>> 1;
          running_area[idx] = clip48(running_area[idx - 1] + area);
        end
        prev_value = y;
        next_index = idx + 1;
        if (idx + 1 > written_hi) written_hi = idx + 1;
      end else r.err = 1'b1;
    end else begin
      t = it.qt;
      n = (cfg_cnt > SAMPLE_DEPTH) ? SAMPLE_DEPTH : cfg_cnt;
      if (t < 0) begin
        r.fv = 0;
        r.iv = 0;
      end else if (n == 0) begin
        r.fv = cfg_bl;
        r.iv = clip48((cfg_bl * t) >>> FRAC_W);
      end else if (t > cfg_et) begin
        if (cfg_cyc != 0 && cfg_et > 0) begin
          q = t / cfg_et;
          u = t - q * cfg_et;
          r.fv = value_at_time(u, n - 1);
          r.iv = clip48(area_times(area_to_time(cfg_et, n - 1), q) + area_to_time(u, n - 1));
        end else begin
          r.fv = cfg_bl;
          r.iv = clip48(area_to_time(cfg_et, n - 1) + ((cfg_bl * (t - cfg_et)) >>> FRAC_W));
        end
      end else begin
        r.fv = value_at_time(t, n - 1);
        r.iv = area_to_time(t, n - 1);
      end
    end
    return r;
  endfunction

  task automatic write_reg(logic [REG_IDX_W-1:0] ri, logic [31:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'(ri) << 2;
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    case (ri)
      REG_SAMPLE_COUNT:  cfg_cnt = v[COUNT_W-1:0];
      REG_INTERP_MODE:   cfg_mode = v[MODE_W-1:0];
      REG_BORDER_CYCLIC: cfg_cyc = v[0];
      REG_BORDER_LEVEL:  cfg_bl = longint'($signed(v));
      REG_END_TIME:      cfg_et = v[END_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(setting_t s);
    write_reg(REG_SAMPLE_COUNT, 32'(s.cnt));
    write_reg(REG_INTERP_MODE, 32'(s.mode));
    write_reg(REG_BORDER_CYCLIC, 32'(s.cyc));
    write_reg(REG_BORDER_LEVEL, s.bl);
    write_reg(REG_END_TIME, 32'(s.et));
  endtask

  task automatic drain;
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // drives one request and records its expected result on acceptance
  task automatic send_item(plan_row_t it);
    interp_result_t r;
    bit took;
    while ($urandom_range(99) < src_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.req_type <= it.rt;
    req_ch.sample_index <= it.idx;
    req_ch.sample_value <= it.val;
    req_ch.query_time <= it.qt;
    do begin
      @(negedge clk);
      took = req_ch.ready;
      @(posedge clk);
    end while (!took);
    r = interp_predict(it);
    if (it.typed) r = '{it.efv, it.eiv, it.eerr};
    pending_results.push_back(r);
    if (it.rt == REQ_LOAD) sent_loads++;
    else sent_queries++;
  endtask

  function automatic plan_row_t random_item();
    plan_row_t it;
    int r, n;
    longint t;
    it = '{0, REQ_QUERY, 0, 0, 0, 0, 0, 0, 0};
    r = $urandom_range(99);
    n = (cfg_cnt > SAMPLE_DEPTH) ? SAMPLE_DEPTH : cfg_cnt;
    if (r < 30) begin
      it.rt = REQ_LOAD;
      if (r < 3) it.idx = $urandom_range(0, SAMPLE_DEPTH - 1);
      else if (r < 5 || next_index >= SAMPLE_DEPTH) it.idx = 0;
      else it.idx = next_index;
      it.val = ($urandom_range(1) == 1) ? $urandom() : $signed($urandom_range(0, 32'h7FFFF)) - 32'sh40000;
      return it;
    end
    r = $urandom_range(99);
    if (r < 40) t = $urandom_range(0, (n + 1) * 65536);
    else if (r < 60) t = cfg_et + $signed($urandom_range(0, 131072)) - 65536;
    else if (r < 80) t = $urandom_range(0, 4 * cfg_et + 65536);
    else if (r < 90) t = -longint'($urandom_range(1, 32'h7FFFFFFF));
    else t = longint'($signed($urandom()));
    it.qt = t[31:0];
    return it;
  endfunction

  function automatic setting_t random_setting();
    setting_t s;
    int r;
    s.cnt = ($urandom_range(9) == 0) ? 0 : $urandom_range(0, written_hi);
    s.mode = $urandom_range(0, 3);
    s.cyc = $urandom_range(0, 1);
    s.bl = $urandom();
    r = $urandom_range(9);
    if (r == 0) s.et = 0;
    else if (r == 1) s.et = END_MAX;
    else s.et = ($urandom_range(0, s.cnt + 2) << FRAC_W) + $urandom_range(0, 65535);
    return s;
  endfunction

  always @(posedge clk) rsp_ch.ready <= ($urandom_range(99) >= snk_stall_pct);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("sampled_function_interpolator verification failed");
      $finish;
    end
  end

  // result transactions are sampled mid-cycle, ahead of the accepting edge
  always @(negedge clk) begin
    interp_result_t exp_r;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result transaction");
        mismatches++;
      end else begin
        exp_r = pending_results.pop_front();
        checked++;
        if (rsp_ch.func_value !== exp_r.fv) begin
          $error("func_value expected %0d got %0d", exp_r.fv, rsp_ch.func_value);
          mismatches++;
        end
        if (rsp_ch.integral_value !== exp_r.iv) begin
          $error("integral_value expected %0d got %0d", exp_r.iv, rsp_ch.integral_value);
          mismatches++;
        end
        if (rsp_ch.load_error !== exp_r.err) begin
          $error("load_error expected %0d got %0d", exp_r.err, rsp_ch.load_error);
          mismatches++;
        end
      end
    end
  end

  initial begin
    setting_t s;
    int ph;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    req_ch.valid = 1'b0;
    req_ch.req_type = REQ_LOAD;
    req_ch.sample_index = '0;
    req_ch.sample_value = '0;
    req_ch.query_time = '0;
    rsp_ch.ready = 1'b0;
    cycles = 0;
    mismatches = 0;
    checked = 0;
    sent_loads = 0;
    sent_queries = 0;
    next_index = 0;
    prev_value = 0;
    written_hi = 0;
    cfg_cnt = 0;
    cfg_mode = 0;
    cfg_cyc = 0;
    cfg_bl = 0;
    cfg_et = 0;
    src_idle_pct = 34;
    snk_stall_pct = 51;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    ph = 0;
    foreach (load_query_plan[i]) begin
      if (load_query_plan[i].ph != ph) begin
        drain();
        ph = load_query_plan[i].ph;
        apply_setting(plan_settings[ph]);
      end
      send_item(load_query_plan[i]);
    end
    drain();

    for (int p = 0; p < 8; p++) begin
      if (p == 3) begin
        src_idle_pct = 51;
        snk_stall_pct = 34;
      end else if (p == 6) begin
        src_idle_pct = 0;
        snk_stall_pct = 0;
      end
      apply_setting(random_setting());
      repeat (50) send_item(random_item());
      drain();
    end

    // widest end time over the table built so far, cyclic then border
    s = '{COUNT_W'(written_hi), MODE_LINEAR, 1'b1, 32'h0, END_MAX};
    s.mode = $urandom_range(0, 3);
    s.bl = $urandom();
    apply_setting(s);
    repeat (20) send_item(random_item());
    drain();
    s = '{COUNT_W'(written_hi), MODE_LINEAR, 1'b0, 32'h0, END_MAX};
    s.bl = $urandom();
    apply_setting(s);
    repeat (20) send_item(random_item());
    drain();
    repeat (200) @(posedge clk);

    $display("run covered %0d loads and %0d queries, %0d results checked",
             sent_loads, sent_queries, checked);
    $display("directed, random and widest end time settings, tables up to %0d samples",
             written_hi);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("sampled_function_interpolator verification clean");
    end else begin
      $display("sampled_function_interpolator verification failed");
    end
    $finish;
  end

endmodule
